/* design/tkhl_pkg.sv */
// Shared types, constants and hash arithmetic for the two-slot keyword hash lookup.
// No dependencies; imported by tkhl_table and two_slot_keyword_hash_lookup.
`timescale 1ns / 1ps

package tkhl_pkg;

	// Default sizing, handed to the top level as parameter defaults
	localparam int MAX_ENTRIES_DEF  = 128;
	localparam int MAX_WORD_LEN_DEF = 8;

	// Fixed geometry
	localparam int BUCKETS  = 256;
	localparam int BKT_W    = 8;
	localparam int SLOT_W   = 8;
	localparam int CHAR_W   = 8;
	localparam int EIDX_W   = 7;
	localparam int STATUS_W = 2;

	localparam logic [SLOT_W-1:0] EMPTY_SLOT = 8'hff;
	localparam logic [7:0]        HASH_MUL   = 8'd75;

	// Request kind carried on tuser
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_TOO_LONG  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BUCKET,
		S_ENTRY
	} state_t;

	// Bucket memory access: one registered read, one write per cycle
	typedef struct packed {
		logic                  rd_en;
		logic [BKT_W-1:0]      rd_addr;
		logic                  wr_en;
		logic [BKT_W-1:0]      wr_addr;
		logic [2*SLOT_W-1:0]   wr_slots;
	} bkt_req_t;

	// Multiply by 75 modulo 256 as shift-and-add (75 = 64 + 8 + 2 + 1)
	function automatic logic [7:0] mul_75(input logic [7:0] x);
		logic [7:0] r;
		r = (x << 6) + (x << 3) + (x << 1) + x;
		return r;
	endfunction

	// One character folded into the running hash; only the low byte of the
	// sign-extended character matters modulo 256
	function automatic logic [7:0] hash_step(input logic [7:0] h, input logic [7:0] c);
		logic [7:0] r;
		r = mul_75(h ^ mul_75(c));
		return r;
	endfunction

endpackage

/* design/two_slot_keyword_hash_lookup.sv */
// Top level of the two-slot keyword hash lookup: word assembly, sequencing, result register.
// Depends on tkhl_pkg and instantiates tkhl_table.
`timescale 1ns / 1ps

// Keyword table engine. Words stream in one character per transfer on the slave
// side, tlast marking the final character and tuser selecting insert (0) or
// lookup (1); the kind on the final character decides. Each character folds into
// an 8-bit running hash that picks one of 256 buckets, each holding up to two
// entry indices. An ordinary character is taken and folded in. The final
// character is followed by a bucket memory read, after which an insert (or an
// over-long word of either kind) completes; a lookup then reads both named
// entries from the entry memory in parallel and compares before it completes.
// No new character is taken until the word in hand has been resolved, and the
// last step also waits while a previous result still sits untaken in the
// output register. One result transfer leaves per word, none per character.
// Buckets come out of reset empty through per-bucket valid bits, so there is
// no clearing pass. Entry storage is undefined until an insert writes it; a
// bucket only ever names written entries.
module two_slot_keyword_hash_lookup import tkhl_pkg::*; #(
	parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
	parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave side: one word character per transfer
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] char_code, [14:8] entry_index, [15] zero
	input  logic        s_axis_tlast,   // last_char
	input  logic        s_axis_tuser,   // [0] func
	// Master side: one result per word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [1:0] status, [8:2] match_index, [16:9] bucket,
	                                    // [23:17] zero
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
	localparam int BI_W  = $clog2(MAX_WORD_LEN);
	localparam int WORD_W = MAX_WORD_LEN * CHAR_W;
	localparam int ENT_W = WORD_W + LEN_W;
	localparam logic [SLOT_W-1:0] ENT_LIMIT = SLOT_W'(MAX_ENTRIES);
	localparam logic [LEN_W-1:0]  LEN_LIMIT = LEN_W'(MAX_WORD_LEN);

	// Input fields
	logic [CHAR_W-1:0] char_code;
	logic [EIDX_W-1:0] entry_index;
	logic              in_xfer;

	assign char_code   = s_axis_tdata[CHAR_W-1:0];
	assign entry_index = s_axis_tdata[CHAR_W +: EIDX_W];
	assign in_xfer     = s_axis_tvalid && s_axis_tready;

	// Word being assembled
	logic [7:0]        hash_q;
	logic [WORD_W-1:0] wbuf_q;
	logic [LEN_W-1:0]  wlen_q;
	logic              ovl_q;

	logic [7:0]        hash_nxt;
	logic [WORD_W-1:0] wbuf_nxt;
	logic [LEN_W-1:0]  wlen_nxt;
	logic              ovl_nxt;

	// Finished word held for the table stage
	logic [7:0]        hash_s1;
	logic [WORD_W-1:0] word_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              ovl_s1;
	logic              func_s1;
	logic [EIDX_W-1:0] eidx_s1;

	// Sequencer and table interface
	state_t              state_q;
	state_t              state_nxt;
	bkt_req_t            bkt_req;
	logic [2*SLOT_W-1:0] bkt_rd_slots;
	logic [SLOT_W-1:0]   slot0;
	logic [SLOT_W-1:0]   slot1;
	logic                ent_wr_en;
	logic                ent_rd_en;
	logic [IDX_W-1:0]    ent_wr_addr;
	logic [IDX_W-1:0]    ent_rd_addr0;
	logic [IDX_W-1:0]    ent_rd_addr1;
	logic [ENT_W-1:0]    ent_key;
	logic [ENT_W-1:0]    ent_rd_data0;
	logic [ENT_W-1:0]    ent_rd_data1;

	// Result register
	logic              out_free;
	logic              commit;
	status_t           res_status;
	logic [EIDX_W-1:0] res_match;
	logic              out_vld_q;
	status_t           status_q;
	logic [EIDX_W-1:0] match_q;
	logic [BKT_W-1:0]  bucket_q;

	// ------------------------------------------------------------------
	// Character intake: hash, store while there is room, flag overflow
	// ------------------------------------------------------------------
	always_comb begin
		hash_nxt = hash_step(hash_q, char_code);
		wbuf_nxt = wbuf_q;
		wlen_nxt = wlen_q;
		ovl_nxt  = ovl_q;
		if (wlen_q < LEN_LIMIT) begin
			wbuf_nxt[wlen_q[BI_W-1:0]*CHAR_W +: CHAR_W] = char_code;
			wlen_nxt = wlen_q + LEN_W'(1);
		end else begin
			ovl_nxt = 1'b1;
		end
	end

	// Advance on every character; clear the running word once it is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			wbuf_q <= '0;
			wlen_q <= '0;
			ovl_q  <= 1'b0;
		end else if (in_xfer) begin
			if (s_axis_tlast) begin
				hash_q <= '0;
				wbuf_q <= '0;
				wlen_q <= '0;
				ovl_q  <= 1'b0;
			end else begin
				hash_q <= hash_nxt;
				wbuf_q <= wbuf_nxt;
				wlen_q <= wlen_nxt;
				ovl_q  <= ovl_nxt;
			end
		end
	end

	// Capture the completed word; held until the result is committed
	always_ff @(posedge clk) begin
		if (in_xfer && s_axis_tlast) begin
			hash_s1 <= hash_nxt;
			word_s1 <= wbuf_nxt;
			len_s1  <= wlen_nxt;
			ovl_s1  <= ovl_nxt;
			func_s1 <= s_axis_tuser;
			eidx_s1 <= entry_index;
		end
	end

	// ------------------------------------------------------------------
	// Table memories
	// ------------------------------------------------------------------
	assign slot0        = bkt_rd_slots[SLOT_W-1:0];
	assign slot1        = bkt_rd_slots[2*SLOT_W-1:SLOT_W];
	assign ent_rd_addr0 = IDX_W'(slot0);
	assign ent_rd_addr1 = IDX_W'(slot1);
	assign ent_wr_addr  = IDX_W'({1'b0, eidx_s1});
	assign ent_key      = {len_s1, word_s1};

	tkhl_table #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.MAX_WORD_LEN (MAX_WORD_LEN)
	) u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.bkt_req      (bkt_req),
		.bkt_rd_slots (bkt_rd_slots),
		.ent_wr_en    (ent_wr_en),
		.ent_wr_addr  (ent_wr_addr),
		.ent_wr_data  (ent_key),
		.ent_rd_en    (ent_rd_en),
		.ent_rd_addr0 (ent_rd_addr0),
		.ent_rd_addr1 (ent_rd_addr1),
		.ent_rd_data0 (ent_rd_data0),
		.ent_rd_data1 (ent_rd_data1)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	assign out_free = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer && s_axis_tlast) begin
					state_nxt = S_BUCKET;
				end
			end
			S_BUCKET: begin
				if (!ovl_s1 && func_s1 == FUNC_LOOKUP) begin
					state_nxt = S_ENTRY;
				end else if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_ENTRY: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Outputs: memory accesses and the result to commit
	always_comb begin
		s_axis_tready    = 1'b0;
		bkt_req.rd_en    = 1'b0;
		bkt_req.rd_addr  = hash_nxt;
		bkt_req.wr_en    = 1'b0;
		bkt_req.wr_addr  = hash_s1;
		bkt_req.wr_slots = bkt_rd_slots;
		ent_wr_en        = 1'b0;
		ent_rd_en        = 1'b0;
		commit           = 1'b0;
		res_status       = ST_OK;
		res_match        = '0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				// Fetch the bucket as the final character lands
				bkt_req.rd_en = s_axis_tvalid && s_axis_tlast;
			end
			S_BUCKET: begin
				if (ovl_s1) begin
					res_status = ST_TOO_LONG;
					commit     = out_free;
				end else if (func_s1 == FUNC_LOOKUP) begin
					ent_rd_en = 1'b1;
				end else begin
					commit = out_free;
					if ({1'b0, eidx_s1} >= ENT_LIMIT) begin
						res_status = ST_FULL;
					end else if (slot0 == EMPTY_SLOT) begin
						bkt_req.wr_slots = {slot1, 1'b0, eidx_s1};
						res_match        = eidx_s1;
					end else if (slot1 == EMPTY_SLOT) begin
						bkt_req.wr_slots = {1'b0, eidx_s1, slot0};
						res_match        = eidx_s1;
					end else begin
						res_status = ST_FULL;
					end
					// Store only when the insert succeeds and the result can leave
					if (res_status == ST_OK) begin
						bkt_req.wr_en = out_free;
						ent_wr_en     = out_free;
					end
				end
			end
			S_ENTRY: begin
				commit     = out_free;
				res_status = ST_NOT_FOUND;
				// Slots fill in order, so an empty first slot ends the search
				if (slot0 != EMPTY_SLOT) begin
					if (ent_rd_data0 == ent_key) begin
						res_status = ST_OK;
						res_match  = slot0[EIDX_W-1:0];
					end else if (slot1 != EMPTY_SLOT && ent_rd_data1 == ent_key) begin
						res_status = ST_OK;
						res_match  = slot1[EIDX_W-1:0];
					end
				end
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= res_status;
			match_q  <= res_match;
			bucket_q <= hash_s1;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'd0, bucket_q, match_q, status_q};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// A result appears only after the table stage has run
	a_result_from_table: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(state_q) == S_BUCKET || $past(state_q) == S_ENTRY))
		else $error("result raised outside the table stage");

	// Bucket and entry writes go together, and only for an insert being committed
	a_write_pairing: assert property (@(posedge clk) disable iff (!arst_n)
		bkt_req.wr_en |-> (ent_wr_en && commit && state_q == S_BUCKET &&
			func_s1 == FUNC_INSERT && !ovl_s1))
		else $error("table write without a committed insert");

	// Entry reads are issued only for a lookup of a word that fits
	a_entry_read: assert property (@(posedge clk) disable iff (!arst_n)
		ent_rd_en |=> (state_q == S_ENTRY && func_s1 == FUNC_LOOKUP && !ovl_s1))
		else $error("entry read not followed by compare stage");

	// Any result other than success carries a zero index
	a_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && status_q != ST_OK) |-> (match_q == '0))
		else $error("non-zero index on a failed result");

	// The stored length never passes the buffer size
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wlen_q <= LEN_LIMIT)
		else $error("word length beyond buffer");

endmodule

/* design/tkhl_table.sv */
// Bucket slot memory (with per-bucket valid bits) and entry name memory.
// Depends on tkhl_pkg for the bucket request struct and slot constants.
`timescale 1ns / 1ps

module tkhl_table import tkhl_pkg::*; #(
	parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
	parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
	localparam int IDX_W = $clog2(MAX_ENTRIES),
	localparam int LEN_W = $clog2(MAX_WORD_LEN + 1),
	localparam int ENT_W = MAX_WORD_LEN * CHAR_W + LEN_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bkt_req_t            bkt_req,
	output logic [2*SLOT_W-1:0] bkt_rd_slots,
	input  logic                ent_wr_en,
	input  logic [IDX_W-1:0]    ent_wr_addr,
	input  logic [ENT_W-1:0]    ent_wr_data,
	input  logic                ent_rd_en,
	input  logic [IDX_W-1:0]    ent_rd_addr0,
	input  logic [IDX_W-1:0]    ent_rd_addr1,
	output logic [ENT_W-1:0]    ent_rd_data0,
	output logic [ENT_W-1:0]    ent_rd_data1
);

	logic [2*SLOT_W-1:0] bkt_mem [BUCKETS];
	logic [BUCKETS-1:0]  bkt_vld_q;
	logic [2*SLOT_W-1:0] bkt_rd_q;
	logic                bkt_rd_vld_q;

	logic [ENT_W-1:0]    ent_mem [MAX_ENTRIES];
	logic [ENT_W-1:0]    ent_rd0_q;
	logic [ENT_W-1:0]    ent_rd1_q;

	// Bucket memory body and read port
	always_ff @(posedge clk) begin
		if (bkt_req.wr_en) begin
			bkt_mem[bkt_req.wr_addr] <= bkt_req.wr_slots;
		end
		if (bkt_req.rd_en) begin
			bkt_rd_q <= bkt_mem[bkt_req.rd_addr];
		end
	end

	// A bucket never written reads as two empty slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkt_vld_q    <= '0;
			bkt_rd_vld_q <= 1'b0;
		end else begin
			if (bkt_req.wr_en) begin
				bkt_vld_q[bkt_req.wr_addr] <= 1'b1;
			end
			if (bkt_req.rd_en) begin
				bkt_rd_vld_q <= bkt_vld_q[bkt_req.rd_addr];
			end
		end
	end

	assign bkt_rd_slots = bkt_rd_vld_q ? bkt_rd_q : {EMPTY_SLOT, EMPTY_SLOT};

	// Entry memory: one write port, two read ports
	always_ff @(posedge clk) begin
		if (ent_wr_en) begin
			ent_mem[ent_wr_addr] <= ent_wr_data;
		end
		if (ent_rd_en) begin
			ent_rd0_q <= ent_mem[ent_rd_addr0];
			ent_rd1_q <= ent_mem[ent_rd_addr1];
		end
	end

	assign ent_rd_data0 = ent_rd0_q;
	assign ent_rd_data1 = ent_rd1_q;

endmodule
